[hw/rtl/lzwbse_pkg.sv]
// shared types, constants and state codes of the lzw byte stream encoder
`timescale 1ns / 1ps

package lzwbse_pkg;

    // dictionary geometry
    localparam int DICT_SLOTS = 4096;
    localparam int SLOT_BITS  = $clog2(DICT_SLOTS);
    localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(DICT_SLOTS - 1);

    // epoch tags mark live entries, zero marks a swept entry
    localparam int EPOCH_BITS = 6;
    localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
    localparam logic [EPOCH_BITS-1:0] EPOCH_MAX   = {EPOCH_BITS{1'b1}};

    localparam logic [31:0] HASH_MUL   = 32'd2654435761;
    localparam logic [11:0] CODE_CLEAR = 12'd256;
    localparam logic [11:0] CODE_END   = 12'd257;
    localparam logic [12:0] FIRST_FREE = 13'd258;
    localparam logic [12:0] CODE_LIMIT = 13'd4096;
    localparam logic [12:0] GROW_10    = 13'd512;
    localparam logic [12:0] GROW_11    = 13'd1024;
    localparam logic [12:0] GROW_12    = 13'd2048;
    localparam logic [3:0]  WIDTH_MIN  = 4'd9;

    typedef logic [SLOT_BITS-1:0] slot_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       empty_stream;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       stream_end;
    } out_item_t;

    typedef struct packed {
        logic [EPOCH_BITS-1:0] epoch;
        logic [19:0]           key;
        logic [11:0]           code;
    } entry_t;

    // one code word handed to the bit packer
    typedef struct packed {
        logic [11:0] code;
        logic [3:0]  width;
        logic        last_code;
        logic        closes;
    } pack_req_t;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_READ,
        ST_PROBE,
        ST_DECIDE,
        ST_EMIT
    } enc_state_t;

endpackage

[hw/rtl/lzwbse_ram.sv]
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module lzwbse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/lzwbse_pack.sv]
// msb-first bit packer with output register and end flags
`timescale 1ns / 1ps

module lzwbse_pack (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  lzwbse_pkg::pack_req_t req,
    output logic                  req_ready,
    output logic                  chunk_valid,
    input  logic                  chunk_stall,
    output lzwbse_pkg::out_item_t chunk
);

    logic [18:0]           acc_reg, acc_next;
    logic [4:0]            cnt_reg, cnt_next;
    logic                  last_code_reg, last_code_next;
    logic                  closes_reg, closes_next;
    logic                  out_valid_reg, out_valid_next;
    lzwbse_pkg::out_item_t out_reg, out_next;

    logic        slot_free;
    logic        flush_due;
    logic [4:0]  rem;
    logic [11:0] code_masked;

    assign slot_free   = !out_valid_reg || !chunk_stall;
    assign rem         = cnt_reg - 5'd8;
    // leftover bits of a closing code go out zero-padded
    assign flush_due   = last_code_reg && closes_reg && (cnt_reg != 5'd0) && (cnt_reg < 5'd8);
    assign req_ready   = (cnt_reg < 5'd8) && !flush_due;
    assign code_masked = req.code & ((12'd1 << req.width) - 12'd1);

    always_comb
    begin
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        last_code_next = last_code_reg;
        closes_next    = closes_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && chunk_stall;
        priority if (req_valid && req_ready)
        begin
            acc_next       = (acc_reg << req.width) | {7'b0, code_masked};
            cnt_next       = cnt_reg + {1'b0, req.width};
            last_code_next = req.last_code;
            closes_next    = req.closes;
        end
        else if (slot_free && (cnt_reg >= 5'd8))
        begin
            out_next.out_byte   = 8'(acc_reg >> rem);
            out_next.run_end    = last_code_reg && (rem < 5'd8)
                                  && !(closes_reg && (rem != 5'd0));
            out_next.stream_end = last_code_reg && closes_reg && (rem == 5'd0);
            cnt_next            = rem;
            out_valid_next      = 1'b1;
        end
        else if (slot_free && flush_due)
        begin
            out_next.out_byte   = 8'(acc_reg << (5'd8 - cnt_reg));
            out_next.run_end    = 1'b1;
            out_next.stream_end = 1'b1;
            cnt_next            = 5'd0;
            out_valid_next      = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && chunk_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= 5'd0;
            last_code_reg <= 1'b0;
            closes_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            last_code_reg <= last_code_next;
            closes_reg    <= closes_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        out_reg <= out_next;
    end

    assign chunk_valid = out_valid_reg;
    assign chunk       = out_reg;

endmodule

[hw/rtl/lzw_byte_stream_encoder.sv]
// lzw byte stream encoder: hashed dictionary in one ram, sequencer and bit packer
// each byte: read the hashed slot, probe linearly until a hit or a dead entry, decide, emit;
//   each code word goes to the packer in turn, and every word after the first waits for the packer
// one request at a time; stream starts and empty markers skip the probe
// reset: control state cleared, then a sweep of every slot of the dictionary ram;
//   the same sweep runs after every EPOCH_MAX dictionary clears
`timescale 1ns / 1ps

module lzw_byte_stream_encoder (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  symbol_valid,
    output logic                  symbol_stall,
    input  lzwbse_pkg::in_item_t  symbol,
    output logic                  chunk_valid,
    input  logic                  chunk_stall,
    output lzwbse_pkg::out_item_t chunk
);

    lzwbse_pkg::enc_state_t state_reg, state_next;

    logic [7:0]                       byte_reg, byte_next;
    logic                             last_reg, last_next;
    logic                             empty_reg, empty_next;
    logic [19:0]                      key_reg, key_next;
    logic [31:0]                      m_reg, m_next;
    lzwbse_pkg::slot_t                probe_addr_reg, probe_addr_next;
    logic                             found_reg, found_next;
    logic [11:0]                      found_code_reg, found_code_next;
    logic [11:0]                      prefix_reg, prefix_next;
    logic [12:0]                      nfc_reg, nfc_next;
    logic [3:0]                       cw_reg, cw_next;
    logic                             in_stream_reg, in_stream_next;
    logic [lzwbse_pkg::EPOCH_BITS-1:0] epoch_reg, epoch_next;
    lzwbse_pkg::slot_t                sweep_reg, sweep_next;
    logic                             sweep_pend_reg, sweep_pend_next;
    logic [11:0]                      code_list_reg [4];
    logic [11:0]                      code_list_next [4];
    logic [3:0]                       width_list_reg [4];
    logic [3:0]                       width_list_next [4];
    logic [2:0]                       code_cnt_reg, code_cnt_next;
    logic                             close_list_reg, close_list_next;
    logic [1:0]                       idx_reg, idx_next;

    logic                             ram_we;
    lzwbse_pkg::slot_t                ram_waddr;
    lzwbse_pkg::entry_t               ram_wdata;
    lzwbse_pkg::slot_t                ram_raddr;
    logic [$bits(lzwbse_pkg::entry_t)-1:0] ram_rdata;
    lzwbse_pkg::entry_t               entry;

    logic [63:0]                      slot_prod;
    lzwbse_pkg::slot_t                hash_slot;
    lzwbse_pkg::slot_t                probe_wrap;

    logic                             req_valid;
    lzwbse_pkg::pack_req_t            req;
    logic                             req_ready;

    assign entry      = lzwbse_pkg::entry_t'(ram_rdata);
    // slot = (m * DICT_SLOTS) >> 32
    assign slot_prod  = {32'b0, m_reg} * 64'(lzwbse_pkg::DICT_SLOTS);
    assign hash_slot  = slot_prod[32 +: lzwbse_pkg::SLOT_BITS];
    assign probe_wrap = (probe_addr_reg == lzwbse_pkg::SLOT_LAST) ? '0
                        : probe_addr_reg + lzwbse_pkg::slot_t'(1);

    assign symbol_stall = (state_reg != lzwbse_pkg::ST_IDLE);

    assign req.code      = code_list_reg[idx_reg];
    assign req.width     = width_list_reg[idx_reg];
    assign req.last_code = (({1'b0, idx_reg} + 3'd1) == code_cnt_reg);
    assign req.closes    = req.last_code && close_list_reg;

    always_comb
    begin
        logic [11:0]                       p;
        logic [12:0]                       nf;
        logic [3:0]                        w;
        logic                              ins;
        logic [2:0]                        n;
        logic                              cls;
        logic                              clr;
        logic [lzwbse_pkg::EPOCH_BITS-1:0] ep;
        logic                              pend;

        state_next       = state_reg;
        byte_next        = byte_reg;
        last_next        = last_reg;
        empty_next       = empty_reg;
        key_next         = key_reg;
        m_next           = m_reg;
        probe_addr_next  = probe_addr_reg;
        found_next       = found_reg;
        found_code_next  = found_code_reg;
        prefix_next      = prefix_reg;
        nfc_next         = nfc_reg;
        cw_next          = cw_reg;
        in_stream_next   = in_stream_reg;
        epoch_next       = epoch_reg;
        sweep_next       = sweep_reg;
        sweep_pend_next  = sweep_pend_reg;
        code_list_next   = code_list_reg;
        width_list_next  = width_list_reg;
        code_cnt_next    = code_cnt_reg;
        close_list_next  = close_list_reg;
        idx_next         = idx_reg;
        ram_we           = 1'b0;
        ram_waddr        = probe_addr_reg;
        ram_wdata        = '{epoch: epoch_reg, key: key_reg, code: nfc_reg[11:0]};
        ram_raddr        = probe_addr_reg;
        req_valid        = 1'b0;

        p    = prefix_reg;
        nf   = nfc_reg;
        w    = cw_reg;
        ins  = in_stream_reg;
        n    = 3'd0;
        cls  = 1'b0;
        clr  = 1'b0;
        ep   = epoch_reg;
        pend = sweep_pend_reg;

        unique case (state_reg)
            lzwbse_pkg::ST_SWEEP:
            begin
                ram_we    = 1'b1;
                ram_waddr = sweep_reg;
                ram_wdata = '0;
                if (sweep_reg == lzwbse_pkg::SLOT_LAST)
                begin
                    sweep_next = '0;
                    state_next = lzwbse_pkg::ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + lzwbse_pkg::slot_t'(1);
                end
            end

            lzwbse_pkg::ST_IDLE:
            begin
                if (symbol_valid)
                begin
                    byte_next  = symbol.data_byte;
                    last_next  = symbol.last_byte;
                    empty_next = symbol.empty_stream;
                    key_next   = {prefix_reg, symbol.data_byte};
                    m_next     = {12'b0, prefix_reg, symbol.data_byte} * lzwbse_pkg::HASH_MUL;
                    if (in_stream_reg && !symbol.empty_stream)
                    begin
                        state_next = lzwbse_pkg::ST_READ;
                    end
                    else
                    begin
                        state_next = lzwbse_pkg::ST_DECIDE;
                    end
                end
            end

            lzwbse_pkg::ST_READ:
            begin
                ram_raddr       = hash_slot;
                probe_addr_next = hash_slot;
                state_next      = lzwbse_pkg::ST_PROBE;
            end

            lzwbse_pkg::ST_PROBE:
            begin
                priority if (entry.epoch != epoch_reg)
                begin
                    found_next = 1'b0;
                    state_next = lzwbse_pkg::ST_DECIDE;
                end
                else if (entry.key == key_reg)
                begin
                    found_next      = 1'b1;
                    found_code_next = entry.code;
                    state_next      = lzwbse_pkg::ST_DECIDE;
                end
                else
                begin
                    // linear probing, one slot per cycle
                    probe_addr_next = probe_wrap;
                    ram_raddr       = probe_wrap;
                end
            end

            lzwbse_pkg::ST_DECIDE:
            begin
                if (empty_reg)
                begin
                    if (ins)
                    begin
                        code_list_next[0]  = p;
                        width_list_next[0] = w;
                    end
                    else
                    begin
                        code_list_next[0]  = lzwbse_pkg::CODE_CLEAR;
                        width_list_next[0] = lzwbse_pkg::WIDTH_MIN;
                        w                  = lzwbse_pkg::WIDTH_MIN;
                    end
                    n   = 3'd1;
                    cls = 1'b1;
                end
                else
                begin
                    if (!ins)
                    begin
                        // dictionary is already clear outside a stream
                        code_list_next[0]  = lzwbse_pkg::CODE_CLEAR;
                        width_list_next[0] = lzwbse_pkg::WIDTH_MIN;
                        n                  = 3'd1;
                        p                  = {4'b0, byte_reg};
                        ins                = 1'b1;
                        nf                 = lzwbse_pkg::FIRST_FREE;
                        w                  = lzwbse_pkg::WIDTH_MIN;
                    end
                    else if (found_reg)
                    begin
                        p = found_code_reg;
                    end
                    else
                    begin
                        code_list_next[0]  = p;
                        width_list_next[0] = w;
                        n                  = 3'd1;
                        if (nf < lzwbse_pkg::CODE_LIMIT)
                        begin
                            ram_we = 1'b1;
                            nf     = nf + 13'd1;
                            if (nf == lzwbse_pkg::GROW_10)
                            begin
                                w = 4'd10;
                            end
                            else if (nf == lzwbse_pkg::GROW_11)
                            begin
                                w = 4'd11;
                            end
                            else if (nf == lzwbse_pkg::GROW_12)
                            begin
                                w = 4'd12;
                            end
                        end
                        else
                        begin
                            // code space used up: clear at the current width
                            code_list_next[1]  = lzwbse_pkg::CODE_CLEAR;
                            width_list_next[1] = w;
                            n                  = 3'd2;
                            nf                 = lzwbse_pkg::FIRST_FREE;
                            w                  = lzwbse_pkg::WIDTH_MIN;
                            clr                = 1'b1;
                        end
                        p = {4'b0, byte_reg};
                    end
                    if (last_reg)
                    begin
                        code_list_next[n[1:0]]  = p;
                        width_list_next[n[1:0]] = w;
                        n                       = n + 3'd1;
                        cls                     = 1'b1;
                    end
                end

                if (cls)
                begin
                    code_list_next[n[1:0]]  = lzwbse_pkg::CODE_END;
                    width_list_next[n[1:0]] = w;
                    n                       = n + 3'd1;
                    p                       = 12'd0;
                    ins                     = 1'b0;
                    nf                      = lzwbse_pkg::FIRST_FREE;
                    w                       = lzwbse_pkg::WIDTH_MIN;
                end

                // a dictionary clear moves to a fresh epoch, a wrap needs a sweep
                if (clr)
                begin
                    if (ep == lzwbse_pkg::EPOCH_MAX)
                    begin
                        ep   = lzwbse_pkg::EPOCH_FIRST;
                        pend = 1'b1;
                    end
                    else
                    begin
                        ep = ep + {{(lzwbse_pkg::EPOCH_BITS-1){1'b0}}, 1'b1};
                    end
                end
                if (cls)
                begin
                    if (ep == lzwbse_pkg::EPOCH_MAX)
                    begin
                        ep   = lzwbse_pkg::EPOCH_FIRST;
                        pend = 1'b1;
                    end
                    else
                    begin
                        ep = ep + {{(lzwbse_pkg::EPOCH_BITS-1){1'b0}}, 1'b1};
                    end
                end

                prefix_next     = p;
                nfc_next        = nf;
                cw_next         = w;
                in_stream_next  = ins;
                epoch_next      = ep;
                sweep_pend_next = pend;
                code_cnt_next   = n;
                close_list_next = cls;
                idx_next        = 2'd0;
                if (n == 3'd0)
                begin
                    state_next = lzwbse_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = lzwbse_pkg::ST_EMIT;
                end
            end

            lzwbse_pkg::ST_EMIT:
            begin
                req_valid = 1'b1;
                if (req_ready)
                begin
                    if (req.last_code)
                    begin
                        idx_next        = 2'd0;
                        sweep_pend_next = 1'b0;
                        if (sweep_pend_reg)
                        begin
                            state_next = lzwbse_pkg::ST_SWEEP;
                        end
                        else
                        begin
                            state_next = lzwbse_pkg::ST_IDLE;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
            end

            default:
            begin
                state_next = lzwbse_pkg::ST_SWEEP;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lzwbse_pkg::ST_SWEEP;
            prefix_reg     <= 12'd0;
            nfc_reg        <= lzwbse_pkg::FIRST_FREE;
            cw_reg         <= lzwbse_pkg::WIDTH_MIN;
            in_stream_reg  <= 1'b0;
            epoch_reg      <= lzwbse_pkg::EPOCH_FIRST;
            sweep_reg      <= '0;
            sweep_pend_reg <= 1'b0;
            code_cnt_reg   <= 3'd0;
            idx_reg        <= 2'd0;
        end
        else
        begin
            state_reg      <= state_next;
            prefix_reg     <= prefix_next;
            nfc_reg        <= nfc_next;
            cw_reg         <= cw_next;
            in_stream_reg  <= in_stream_next;
            epoch_reg      <= epoch_next;
            sweep_reg      <= sweep_next;
            sweep_pend_reg <= sweep_pend_next;
            code_cnt_reg   <= code_cnt_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg       <= byte_next;
        last_reg       <= last_next;
        empty_reg      <= empty_next;
        key_reg        <= key_next;
        m_reg          <= m_next;
        probe_addr_reg <= probe_addr_next;
        found_reg      <= found_next;
        found_code_reg <= found_code_next;
        code_list_reg  <= code_list_next;
        width_list_reg <= width_list_next;
        close_list_reg <= close_list_next;
    end

    lzwbse_ram #(
        .WIDTH ($bits(lzwbse_pkg::entry_t)),
        .DEPTH (lzwbse_pkg::DICT_SLOTS)
    ) u_dict (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lzwbse_pack u_pack (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req         (req),
        .req_ready   (req_ready),
        .chunk_valid (chunk_valid),
        .chunk_stall (chunk_stall),
        .chunk       (chunk)
    );

endmodule

[hw/rtl/lzwbse_checker.sv]
// port-level checker for the lzw byte stream encoder, bound to the top level
`timescale 1ns / 1ps

module lzwbse_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  symbol_valid,
    input logic                  symbol_stall,
    input lzwbse_pkg::in_item_t  symbol,
    input logic                  chunk_valid,
    input logic                  chunk_stall,
    input lzwbse_pkg::out_item_t chunk
);

    // the final byte of a stream is always the last byte of its request
    a_stream_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        (chunk_valid && chunk.stream_end) |-> chunk.run_end)
    else $error("stream_end without run_end");

    // one request at a time: an accepted byte blocks the next cycle
    a_one_request_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (symbol_valid && !symbol_stall) |=> symbol_stall)
    else $error("input accepted on consecutive cycles");

    // nothing comes out right after reset
    a_quiet_after_reset: assert property (@(posedge clk)
        !rst_n |=> !chunk_valid)
    else $error("output valid straight after reset");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (chunk_valid && chunk_stall) |=> (chunk_valid && $stable(chunk)))
    else $error("stalled output changed");

endmodule

bind lzw_byte_stream_encoder lzwbse_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .symbol_valid (symbol_valid),
    .symbol_stall (symbol_stall),
    .symbol       (symbol),
    .chunk_valid  (chunk_valid),
    .chunk_stall  (chunk_stall),
    .chunk        (chunk)
);

[sim/lzw_byte_stream_encoder_tb.sv]
// testbench for the lzw byte stream encoder: random handshakes, in-bench encoder model, scoreboard
`timescale 1ns / 1ps

module lzw_byte_stream_encoder_tb;

    localparam int unsigned STYLE_ANY     = 0;
    localparam int unsigned STYLE_NARROW  = 1;
    localparam int unsigned STYLE_PATTERN = 2;

    localparam int unsigned ITEM_TARGET   = 360;
    localparam int unsigned HOLD_AFTER    = 80;
    localparam int unsigned HOLD_CYCLES   = 500;
    localparam int unsigned DRAIN_CYCLES  = 200;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  symbol_valid = 1'b0;
    logic                  symbol_stall;
    lzwbse_pkg::in_item_t  symbol = '0;
    logic                  chunk_valid;
    logic                  chunk_stall = 1'b0;
    lzwbse_pkg::out_item_t chunk;

    lzw_byte_stream_encoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .symbol_valid (symbol_valid),
        .symbol_stall (symbol_stall),
        .symbol       (symbol),
        .chunk_valid  (chunk_valid),
        .chunk_stall  (chunk_stall),
        .chunk        (chunk)
    );

    always #5 clk = ~clk;

    // encoder model state
    logic [19:0] dict_key  [lzwbse_pkg::DICT_SLOTS];
    logic [11:0] dict_code [lzwbse_pkg::DICT_SLOTS];
    bit          dict_used [lzwbse_pkg::DICT_SLOTS];
    logic [11:0] prefix;
    logic [12:0] avail_code;
    logic [3:0]  cur_width;
    logic        in_run;
    logic [6:0]  residue;
    int unsigned residue_bits;
    logic [63:0] acc;
    int unsigned acc_n;
    lzwbse_pkg::out_item_t step_bytes [$];

    lzwbse_pkg::in_item_t  pending_requests [$];
    lzwbse_pkg::out_item_t expected_chunks [$];

    int unsigned requests_taken = 0;
    int unsigned total_requests;
    int unsigned bytes_checked = 0;
    int unsigned mismatches = 0;
    int unsigned streams_closed = 0;
    int unsigned full_clears = 0;
    int unsigned widest_code = 9;
    int unsigned gap_left = 0;
    int unsigned phase_left = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    task automatic reset_dict();
        foreach (dict_used[i])
            dict_used[i] = 1'b0;
        avail_code = lzwbse_pkg::FIRST_FREE;
        cur_width = lzwbse_pkg::WIDTH_MIN;
    endtask

    task automatic add_out_byte(input logic [7:0] b);
        lzwbse_pkg::out_item_t item;
        item.out_byte   = b;
        item.run_end    = 1'b0;
        item.stream_end = 1'b0;
        step_bytes = {step_bytes, item};
    endtask

    // append a code word msb first, peeling off whole bytes
    task automatic pack_code(input logic [11:0] value, input int unsigned width);
        acc = (acc << width) | (64'(value) & ((64'd1 << width) - 64'd1));
        acc_n += width;
        while (acc_n >= 8)
        begin
            acc_n -= 8;
            add_out_byte(8'(acc >> acc_n));
        end
        acc &= (64'd1 << acc_n) - 64'd1;
    endtask

    task automatic close_run();
        pack_code(lzwbse_pkg::CODE_END, cur_width);
        if (acc_n > 0)
            add_out_byte(8'(acc << (8 - acc_n)));
        acc = '0;
        acc_n = 0;
        step_bytes[step_bytes.size() - 1].stream_end = 1'b1;
        reset_dict();
        prefix = '0;
        in_run = 1'b0;
        streams_closed++;
    endtask

    task automatic extend_prefix(input logic [7:0] b);
        logic [19:0]       key;
        logic [31:0]       mixed;
        lzwbse_pkg::slot_t slot;
        int unsigned       tries;
        bit                found;
        bit                free_slot;
        key = {prefix, b};
        mixed = 32'(key) * lzwbse_pkg::HASH_MUL;
        slot = lzwbse_pkg::slot_t'(mixed >> (32 - lzwbse_pkg::SLOT_BITS));
        tries = 0;
        found = 1'b0;
        free_slot = 1'b0;
        // linear probe until a hit or an empty slot
        while (!found && !free_slot && tries < lzwbse_pkg::DICT_SLOTS)
        begin
            if (!dict_used[slot])
                free_slot = 1'b1;
            else if (dict_key[slot] == key)
                found = 1'b1;
            else
            begin
                slot = (slot == lzwbse_pkg::SLOT_LAST) ? '0 : slot + 1'b1;
                tries++;
            end
        end
        if (found)
            prefix = dict_code[slot];
        else
        begin
            pack_code(prefix, cur_width);
            if (avail_code < lzwbse_pkg::CODE_LIMIT)
            begin
                if (free_slot)
                begin
                    dict_key[slot]  = key;
                    dict_code[slot] = avail_code[11:0];
                    dict_used[slot] = 1'b1;
                end
                avail_code++;
                if (avail_code == lzwbse_pkg::GROW_10)
                    cur_width = 4'd10;
                else if (avail_code == lzwbse_pkg::GROW_11)
                    cur_width = 4'd11;
                else if (avail_code == lzwbse_pkg::GROW_12)
                    cur_width = 4'd12;
                if (cur_width > widest_code)
                    widest_code = cur_width;
            end
            else
            begin
                // table full: clear code at the current width, then start over
                pack_code(lzwbse_pkg::CODE_CLEAR, cur_width);
                reset_dict();
                full_clears++;
            end
            prefix = {4'd0, b};
        end
    endtask

    task automatic encode_request(input lzwbse_pkg::in_item_t req);
        step_bytes.delete();
        acc = 64'(residue);
        acc_n = residue_bits;
        if (req.empty_stream)
        begin
            if (in_run)
                pack_code(prefix, cur_width);
            else
            begin
                reset_dict();
                pack_code(lzwbse_pkg::CODE_CLEAR, lzwbse_pkg::WIDTH_MIN);
            end
            close_run();
        end
        else
        begin
            if (!in_run)
            begin
                reset_dict();
                pack_code(lzwbse_pkg::CODE_CLEAR, lzwbse_pkg::WIDTH_MIN);
                prefix = {4'd0, req.data_byte};
                in_run = 1'b1;
            end
            else
                extend_prefix(req.data_byte);
            if (req.last_byte)
            begin
                pack_code(prefix, cur_width);
                close_run();
            end
        end
        residue = acc[6:0];
        residue_bits = acc_n;
        if (step_bytes.size() != 0)
            step_bytes[step_bytes.size() - 1].run_end = 1'b1;
        expected_chunks = {expected_chunks, step_bytes};
    endtask

    task automatic queue_request(input logic [7:0] b, input logic last, input logic empty);
        lzwbse_pkg::in_item_t req;
        req.data_byte    = b;
        req.last_byte    = last;
        req.empty_stream = empty;
        pending_requests = {pending_requests, req};
    endtask

    task automatic queue_stream(input int unsigned len, input int unsigned style,
                                input bit cut_short);
        logic [7:0]  base;
        logic [7:0]  pattern [4];
        logic [7:0]  b;
        int unsigned i;
        base = 8'($urandom);
        foreach (pattern[k])
            pattern[k] = 8'($urandom);
        for (i = 0; i < len; i++)
        begin
            unique case (style)
                STYLE_ANY:    b = 8'($urandom);
                STYLE_NARROW: b = base + 8'($urandom_range(0, 3));
                default:      b = ($urandom_range(15) == 0) ? 8'($urandom) : pattern[i % 4];
            endcase
            queue_request(b, (i == len - 1) && !cut_short, 1'b0);
        end
        // a stream closed by an empty marker instead of a last byte
        if (cut_short)
            queue_request(8'($urandom), 1'($urandom), 1'b1);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            symbol_valid <= 1'b0;
            symbol <= '0;
            requests_taken <= 0;
            gap_left = 0;
        end
        else
        begin
            if (symbol_valid && !symbol_stall)
            begin
                encode_request(symbol);
                requests_taken <= requests_taken + 1;
            end
            if (!symbol_valid || !symbol_stall)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    symbol_valid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    symbol <= pending_requests.pop_front();
                    symbol_valid <= 1'b1;
                    gap_left = pick_gap();
                end
                else
                    symbol_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern, with one long hold-off so the input backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_stall <= 1'b0;
            phase_left = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left--;
            chunk_stall <= 1'b1;
        end
        else if (!hold_done && requests_taken >= HOLD_AFTER)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            chunk_stall <= 1'b1;
        end
        else if (phase_left != 0)
            phase_left--;
        else if ($urandom_range(99) < 35)
        begin
            chunk_stall <= 1'b1;
            phase_left = pick_gap();
        end
        else
        begin
            chunk_stall <= 1'b0;
            phase_left = ($urandom_range(9) == 0) ? $urandom_range(30, 80) : pick_gap();
        end
    end

    // output checker
    always @(posedge clk)
    begin
        lzwbse_pkg::out_item_t want;
        if (rst_n && chunk_valid && !chunk_stall)
        begin
            bytes_checked++;
            if (expected_chunks.size() == 0)
            begin
                if (mismatches < 10)
                    $display("%0t: unexpected output byte %02h run_end %0b stream_end %0b",
                             $realtime, chunk.out_byte, chunk.run_end, chunk.stream_end);
                mismatches++;
            end
            else
            begin
                want = expected_chunks.pop_front();
                if (chunk.out_byte !== want.out_byte || chunk.run_end !== want.run_end
                    || chunk.stream_end !== want.stream_end)
                begin
                    if (mismatches < 10)
                        $display("%0t: byte %0d expected %02h/%0b/%0b got %02h/%0b/%0b",
                                 $realtime, bytes_checked, want.out_byte, want.run_end,
                                 want.stream_end, chunk.out_byte, chunk.run_end,
                                 chunk.stream_end);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        int unsigned roll;
        int unsigned len;
        int unsigned style;
        int unsigned room;
        reset_dict();
        prefix = '0;
        in_run = 1'b0;
        residue = '0;
        residue_bits = 0;

        // directed: empty stream alone, one-byte streams at both extremes
        queue_request(8'hFF, 1'b1, 1'b1);
        queue_request(8'h00, 1'b1, 1'b0);
        queue_request(8'hFF, 1'b1, 1'b0);
        // repeated byte, so the prefix grows through dictionary hits
        repeat (4)
            queue_request(8'h41, 1'b0, 1'b0);
        queue_request(8'h41, 1'b1, 1'b0);
        // open stream closed by an empty marker, with and without last set
        queue_request(8'h12, 1'b0, 1'b0);
        queue_request(8'h34, 1'b0, 1'b0);
        queue_request(8'hAB, 1'b0, 1'b1);
        queue_request(8'h80, 1'b0, 1'b0);
        queue_request(8'h7F, 1'b1, 1'b1);
        // back-to-back empty streams
        queue_request(8'h00, 1'b0, 1'b1);
        queue_request(8'h5A, 1'b1, 1'b1);
        repeat (3)
        begin
            queue_request(8'h55, 1'b0, 1'b0);
            queue_request(8'hAA, 1'b0, 1'b0);
        end
        queue_request(8'h55, 1'b1, 1'b0);

        // random streams, mostly short, some long enough to widen the codes
        while (pending_requests.size() < ITEM_TARGET)
        begin
            roll = $urandom_range(99);
            style = $urandom_range(STYLE_PATTERN);
            room = ITEM_TARGET - pending_requests.size();
            if (roll < 8)
                queue_request(8'($urandom), 1'($urandom), 1'b1);
            else
            begin
                len = (roll < 16) ? $urandom_range(100, 300) : $urandom_range(1, 24);
                if (len > room)
                    len = room;
                queue_stream(len, style, $urandom_range(9) == 0);
            end
        end
        total_requests = pending_requests.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (requests_taken != total_requests)
            @(posedge clk);
        while (expected_chunks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d requests in %0d closed streams, %0d output bytes checked",
                 requests_taken, streams_closed, bytes_checked);
        $display("codes up to %0d bits, %0d full-table clears, %0d mismatches",
                 widest_code, full_clears, mismatches);
        if (mismatches == 0 && expected_chunks.size() == 0)
            $display("lzw_byte_stream_encoder_tb: PASS");
        else
            $display("lzw_byte_stream_encoder_tb: FAIL");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("timeout with %0d requests taken and %0d bytes outstanding",
                 requests_taken, expected_chunks.size());
        $display("lzw_byte_stream_encoder_tb: FAIL");
        $finish;
    end

endmodule
